FILE: hw/rtl/wds_pkg.sv
// Shared constants and types of the weighted discrete sampler.
`timescale 1ns / 1ps

package wds_pkg;

    // Table geometry and arithmetic widths.
    localparam int MAX_ENTRIES = 512;
    localparam int WEIGHT_BITS = 16;
    localparam int RANDOM_BITS = 8;
    localparam int ADDR_W      = $clog2(MAX_ENTRIES);
    localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
    localparam int SUM_W       = WEIGHT_BITS + ADDR_W;
    localparam int PROD_W      = SUM_W + RANDOM_BITS;

    // Fixed port widths.
    localparam int IDX_IN_W    = 9;
    localparam int WEIGHT_IN_W = 16;
    localparam int RAND_IN_W   = 8;
    localparam int ENTRIES_W   = 10;
    localparam int OFFSET_W    = 8;
    localparam int VAL_W       = 10;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 10;

    // Widths for range checks and the offset add.
    localparam int IDX_EXT_W = (IDX_IN_W > CNT_W) ? IDX_IN_W : CNT_W;
    localparam int CNT_EXT_W = (ENTRIES_W > CNT_W) ? ENTRIES_W : CNT_W;
    localparam int WGT_EXT_W = (WEIGHT_IN_W > WEIGHT_BITS) ? WEIGHT_IN_W : WEIGHT_BITS;
    localparam int RND_EXT_W = (RAND_IN_W > RANDOM_BITS) ? RAND_IN_W : RANDOM_BITS;
    localparam int VSUM_W    = ((ADDR_W > VAL_W) ? ADDR_W : VAL_W) + 1;

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] CFG_ENTRIES = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET  = 1'b1;

    // Reset values of the configuration registers.
    localparam logic [ENTRIES_W-1:0] ENTRIES_RESET = 10'd360;
    localparam logic [OFFSET_W-1:0]  OFFSET_RESET  = 8'd0;

    // Item request codes.
    localparam logic REQ_WRITE = 1'b0;
    localparam logic REQ_DRAW  = 1'b1;

    // Draw command from the front end to the engine.
    typedef struct packed {
        logic                   go;
        logic                   stale;
        logic [RANDOM_BITS-1:0] rnd;
        logic [CNT_W-1:0]       count;
        logic [OFFSET_W-1:0]    offset;
    } draw_cmd_t;

    // Engine status and result back to the front end.
    typedef struct packed {
        logic             busy;
        logic             rebuilt;
        logic             done;
        logic [VAL_W-1:0] value;
        logic             empty;
    } eng_stat_t;

endpackage

FILE: hw/rtl/wds_ram.sv
// Generic simple dual-port RAM with registered read data.
`timescale 1ns / 1ps

module wds_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 512
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: hw/rtl/wds_engine.sv
// Draw engine: prefix-sum rebuild, threshold scaling and lower-bound search.
`timescale 1ns / 1ps

module wds_engine
    import wds_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  draw_cmd_t              cmd,
    output eng_stat_t              stat,
    output logic [ADDR_W-1:0]      weight_raddr,
    input  logic [WEIGHT_BITS-1:0] weight_rdata,
    output logic                   prefix_we,
    output logic [ADDR_W-1:0]      prefix_waddr,
    output logic [SUM_W-1:0]       prefix_wdata,
    output logic [ADDR_W-1:0]      prefix_raddr,
    input  logic [SUM_W-1:0]       prefix_rdata
);

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_BUILD  = 7'b0000010,
        S_DIFF   = 7'b0000100,
        S_MUL    = 7'b0001000,
        S_TARGET = 7'b0010000,
        S_READ   = 7'b0100000,
        S_CMP    = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    logic                   res_valid_reg, res_valid_next;
    logic [VAL_W-1:0]       res_value_reg, res_value_next;
    logic                   res_empty_reg, res_empty_next;
    logic [RANDOM_BITS-1:0] rnd_reg, rnd_next;
    logic [CNT_W-1:0]       count_reg, count_next;
    logic [ADDR_W-1:0]      last_reg, last_next;
    logic [OFFSET_W-1:0]    offset_reg, offset_next;
    logic [CNT_W-1:0]       rd_cnt_reg, rd_cnt_next;
    logic [ADDR_W-1:0]      wr_idx_reg, wr_idx_next;
    logic                   pend_reg, pend_next;
    logic [SUM_W-1:0]       sum_reg, sum_next;
    logic [SUM_W-1:0]       first_reg, first_next;
    logic [SUM_W-1:0]       total_reg, total_next;
    logic [SUM_W-1:0]       diff_reg, diff_next;
    logic [PROD_W-1:0]      prod_reg, prod_next;
    logic [SUM_W-1:0]       target_reg, target_next;
    logic [ADDR_W-1:0]      lo_reg, lo_next;
    logic [ADDR_W-1:0]      hi_reg, hi_next;
    logic [ADDR_W-1:0]      mid_reg, mid_next;

    logic [SUM_W-1:0]  sum_add;
    logic [ADDR_W:0]   mid_full;
    logic [ADDR_W-1:0] mid;
    logic [CNT_W-1:0]  cnt_m1;
    logic [VSUM_W-1:0] vsum;
    logic              rebuilt;

    // Running sum, midpoint and result value.
    assign sum_add  = sum_reg + SUM_W'(weight_rdata);
    assign mid_full = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign mid      = mid_full[ADDR_W:1];
    assign cnt_m1   = cmd.count - CNT_W'(1);
    assign vsum     = VSUM_W'(lo_reg) + VSUM_W'(offset_reg);

    // Memory address ports.
    assign weight_raddr = rd_cnt_reg[ADDR_W-1:0];
    assign prefix_waddr = wr_idx_reg;
    assign prefix_wdata = sum_add;
    assign prefix_raddr = mid;

    // Sequencer: rebuild the prefix table if needed, scale, then search.
    always_comb
    begin
        state_next     = state_reg;
        res_valid_next = 1'b0;
        res_value_next = res_value_reg;
        res_empty_next = res_empty_reg;
        rnd_next       = rnd_reg;
        count_next     = count_reg;
        last_next      = last_reg;
        offset_next    = offset_reg;
        rd_cnt_next    = rd_cnt_reg;
        wr_idx_next    = wr_idx_reg;
        pend_next      = pend_reg;
        sum_next       = sum_reg;
        first_next     = first_reg;
        total_next     = total_reg;
        diff_next      = diff_reg;
        prod_next      = prod_reg;
        target_next    = target_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        mid_next       = mid_reg;
        prefix_we      = 1'b0;
        rebuilt        = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (cmd.go)
                begin
                    rnd_next    = cmd.rnd;
                    count_next  = cmd.count;
                    last_next   = cnt_m1[ADDR_W-1:0];
                    offset_next = cmd.offset;
                    rd_cnt_next = '0;
                    wr_idx_next = '0;
                    pend_next   = 1'b0;
                    sum_next    = '0;
                    state_next  = cmd.stale ? S_BUILD : S_DIFF;
                end
            end
            S_BUILD:
            begin
                // Reads run one entry ahead of the accumulate-and-write.
                if (rd_cnt_reg < count_reg)
                begin
                    rd_cnt_next = rd_cnt_reg + CNT_W'(1);
                    pend_next   = 1'b1;
                end
                else
                begin
                    pend_next = 1'b0;
                end
                if (pend_reg)
                begin
                    prefix_we   = 1'b1;
                    sum_next    = sum_add;
                    wr_idx_next = wr_idx_reg + ADDR_W'(1);
                    if (wr_idx_reg == '0)
                    begin
                        first_next = sum_add;
                    end
                    if (wr_idx_reg == last_reg)
                    begin
                        total_next = sum_add;
                        rebuilt    = 1'b1;
                        state_next = S_DIFF;
                    end
                end
            end
            S_DIFF:
            begin
                diff_next  = total_reg - first_reg;
                state_next = S_MUL;
            end
            S_MUL:
            begin
                prod_next  = PROD_W'(rnd_reg) * PROD_W'(diff_reg);
                state_next = S_TARGET;
            end
            S_TARGET:
            begin
                target_next = first_reg + prod_reg[RANDOM_BITS +: SUM_W];
                lo_next     = '0;
                hi_next     = last_reg;
                state_next  = S_READ;
            end
            S_READ:
            begin
                if (lo_reg < hi_reg)
                begin
                    mid_next   = mid;
                    state_next = S_CMP;
                end
                else
                begin
                    res_valid_next = 1'b1;
                    res_value_next = vsum[VAL_W-1:0];
                    res_empty_next = (total_reg == '0);
                    state_next     = S_IDLE;
                end
            end
            S_CMP:
            begin
                if (prefix_rdata >= target_reg)
                begin
                    hi_next = mid_reg;
                end
                else
                begin
                    lo_next = mid_reg + ADDR_W'(1);
                end
                state_next = S_READ;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        res_value_reg <= res_value_next;
        res_empty_reg <= res_empty_next;
        rnd_reg       <= rnd_next;
        count_reg     <= count_next;
        last_reg      <= last_next;
        offset_reg    <= offset_next;
        rd_cnt_reg    <= rd_cnt_next;
        wr_idx_reg    <= wr_idx_next;
        pend_reg      <= pend_next;
        sum_reg       <= sum_next;
        first_reg     <= first_next;
        total_reg     <= total_next;
        diff_reg      <= diff_next;
        prod_reg      <= prod_next;
        target_reg    <= target_next;
        lo_reg        <= lo_next;
        hi_reg        <= hi_next;
        mid_reg       <= mid_next;
    end

    // Status back to the front end.
    always_comb
    begin
        stat.busy    = (state_reg != S_IDLE);
        stat.rebuilt = rebuilt;
        stat.done    = res_valid_reg;
        stat.value   = res_value_reg;
        stat.empty   = res_empty_reg;
    end

endmodule

FILE: hw/rtl/weighted_discrete_sampler.sv
// Top level of the weighted discrete sampler: registers, memories and draw engine.
// A write item takes effect at its accept edge and returns no result.
// A draw runs the diff, multiply and target steps, then S read-and-compare search steps,
// S about log2(count), and strobes done. A draw after a weight write or an entry-count
// change first rebuilds the prefix table, one weight read and one prefix write per cycle.
// Reset sets the entry count to 360, the offset to 0 and marks the prefix table stale;
// the memories are not cleared. The receiver cannot stall; busy is high during a draw.
`timescale 1ns / 1ps

module weighted_discrete_sampler
    import wds_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    output logic                   busy,
    input  logic                   req_type,
    input  logic [IDX_IN_W-1:0]    entry_index,
    input  logic [WEIGHT_IN_W-1:0] weight_value,
    input  logic [RAND_IN_W-1:0]   random_byte,
    output logic                   done,
    output logic [VAL_W-1:0]       chosen_value,
    output logic                   empty_flag,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    logic [ENTRIES_W-1:0] entries_reg;
    logic [OFFSET_W-1:0]  offset_reg;
    logic                 stale_reg;

    logic                   cfg_xfer;
    logic                   write_go;
    logic                   draw_go;
    logic [IDX_EXT_W-1:0]   idx_ext;
    logic                   idx_in_range;
    logic [WGT_EXT_W-1:0]   weight_ext;
    logic [RND_EXT_W-1:0]   rnd_ext;
    logic [CNT_EXT_W-1:0]   entries_ext;
    logic [CNT_W-1:0]       active_count;

    draw_cmd_t cmd;
    eng_stat_t stat;

    logic [ADDR_W-1:0]      weight_raddr;
    logic [WEIGHT_BITS-1:0] weight_rdata;
    logic                   prefix_we;
    logic [ADDR_W-1:0]      prefix_waddr;
    logic [SUM_W-1:0]       prefix_wdata;
    logic [ADDR_W-1:0]      prefix_raddr;
    logic [SUM_W-1:0]       prefix_rdata;

    // Handshakes.
    assign cfg_ready = 1'b1;
    assign cfg_xfer  = cfg_valid && cfg_ready;
    assign busy      = stat.busy;
    assign write_go  = start && !busy && (req_type == REQ_WRITE) && idx_in_range;
    assign draw_go   = start && !busy && (req_type == REQ_DRAW);

    // Input field trimming and range check.
    assign idx_ext      = IDX_EXT_W'(entry_index);
    assign idx_in_range = (idx_ext < IDX_EXT_W'(MAX_ENTRIES));
    assign weight_ext   = WGT_EXT_W'(weight_value);
    assign rnd_ext      = RND_EXT_W'(random_byte);

    // Entry count clamped to one through the table depth.
    assign entries_ext = CNT_EXT_W'(entries_reg);
    always_comb
    begin
        if (entries_reg == '0)
        begin
            active_count = CNT_W'(1);
        end
        else if (entries_ext > CNT_EXT_W'(MAX_ENTRIES))
        begin
            active_count = CNT_W'(MAX_ENTRIES);
        end
        else
        begin
            active_count = entries_ext[CNT_W-1:0];
        end
    end

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entries_reg <= ENTRIES_RESET;
            offset_reg  <= OFFSET_RESET;
        end
        else if (cfg_xfer)
        begin
            case (cfg_index)
                CFG_ENTRIES: entries_reg <= cfg_data[ENTRIES_W-1:0];
                CFG_OFFSET:  offset_reg  <= cfg_data[OFFSET_W-1:0];
                default:     entries_reg <= entries_reg;
            endcase
        end
    end

    // The prefix table goes stale on any weight write or entry-count change.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stale_reg <= 1'b1;
        end
        else if (write_go || (cfg_xfer && (cfg_index == CFG_ENTRIES)))
        begin
            stale_reg <= 1'b1;
        end
        else if (stat.rebuilt)
        begin
            stale_reg <= 1'b0;
        end
    end

    // Draw command to the engine.
    always_comb
    begin
        cmd.go     = draw_go;
        cmd.stale  = stale_reg;
        cmd.rnd    = rnd_ext[RANDOM_BITS-1:0];
        cmd.count  = active_count;
        cmd.offset = offset_reg;
    end

    // Weight table.
    wds_ram #(
        .WIDTH (WEIGHT_BITS),
        .DEPTH (MAX_ENTRIES)
    ) u_weight_ram (
        .clk   (clk),
        .we    (write_go),
        .waddr (idx_ext[ADDR_W-1:0]),
        .wdata (weight_ext[WEIGHT_BITS-1:0]),
        .raddr (weight_raddr),
        .rdata (weight_rdata)
    );

    // Cumulative sum table.
    wds_ram #(
        .WIDTH (SUM_W),
        .DEPTH (MAX_ENTRIES)
    ) u_prefix_ram (
        .clk   (clk),
        .we    (prefix_we),
        .waddr (prefix_waddr),
        .wdata (prefix_wdata),
        .raddr (prefix_raddr),
        .rdata (prefix_rdata)
    );

    // Draw engine.
    wds_engine u_engine (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .weight_raddr (weight_raddr),
        .weight_rdata (weight_rdata),
        .prefix_we    (prefix_we),
        .prefix_waddr (prefix_waddr),
        .prefix_wdata (prefix_wdata),
        .prefix_raddr (prefix_raddr),
        .prefix_rdata (prefix_rdata)
    );

    // Result ports.
    assign done         = stat.done;
    assign chosen_value = stat.value;
    assign empty_flag   = stat.empty;

`ifndef SYNTHESIS
    // A result only ends a draw that was in progress.
    assert property (@(posedge clk) disable iff (!rst_n) done |-> $past(busy))
        else $error("result strobe without a draw in progress");

    // The engine only starts on an accepted draw item.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(busy) |-> $past(start && (req_type == REQ_DRAW)))
        else $error("engine started without a draw transfer");

    // The prefix table is only written while a draw is rebuilding it.
    assert property (@(posedge clk) disable iff (!rst_n) prefix_we |-> busy)
        else $error("prefix table written outside a draw");

    // A weight write always leaves the prefix table marked stale.
    assert property (@(posedge clk) disable iff (!rst_n) write_go |=> stale_reg)
        else $error("weight write did not mark the prefix table stale");
`endif

endmodule
